>>> rtl/core/matte_tinted_pixel_blend_macros.svh
// Assertion macros for the matte tinted pixel blend.
// Both macros sample on i_clk and are off while i_rst_n is low.
`ifndef MATTE_TINTED_PIXEL_BLEND_MACROS_SVH
`define MATTE_TINTED_PIXEL_BLEND_MACROS_SVH
`ifndef SYNTHESIS
// ante implies cons in the same cycle
`define MTPB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mtpb: implication check failed");
// ante implies cons, checked after the delay given by lat
`define MTPB_ASSERT_LAT(lbl, ante, lat, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##lat (cons)) \
        else $error("mtpb: latency check failed");
`else
`define MTPB_ASSERT_IMP(lbl, ante, cons)
`define MTPB_ASSERT_LAT(lbl, ante, lat, cons)
`endif
`endif

>>> rtl/core/mtpb_pkg.sv
package mtpb_pkg;

    // channel geometry
    localparam int CH_BITS   = 8;
    localparam int NUM_LANES = 3;
    localparam logic [CH_BITS-1:0] CH_MAX = {CH_BITS{1'b1}};

    // opacity, Q16
    localparam int OPA_BITS = 17;
    localparam int OPA_FRAC = 16;
    localparam logic [OPA_BITS-1:0] OPA_ONE   = OPA_BITS'(1) << OPA_FRAC;
    localparam logic [OPA_BITS-1:0] OPA_HALF  = OPA_BITS'(1) << (OPA_FRAC - 1);
    localparam logic [OPA_BITS-1:0] OPA_RESET = OPA_HALF;

    // widths of the datapath
    localparam int PROD_W = 2 * CH_BITS;
    localparam int SP_W   = CH_BITS + OPA_BITS;
    localparam int NUM_W  = 3 * CH_BITS + 1;
    localparam int Q_W    = CH_BITS + 1;

    // channel sum is divided by MAX*MAX with rounding offset MAX*MAX/2
    localparam longint unsigned DEN   = longint'(CH_MAX) * longint'(CH_MAX);
    localparam longint unsigned HALF  = DEN / 2;
    // floor(2^NUM_W / DEN): quotient estimate is low by at most one
    localparam longint unsigned RECIP = (longint'(1) << NUM_W) / DEN;

    // blend modes
    localparam logic [2:0] MODE_OVER     = 3'd0;
    localparam logic [2:0] MODE_ADD      = 3'd1;
    localparam logic [2:0] MODE_SUB      = 3'd2;
    localparam logic [2:0] MODE_MULTIPLY = 3'd3;
    localparam logic [2:0] MODE_LIGHTEN  = 3'd4;
    localparam logic [2:0] MODE_DARKEN   = 3'd5;

    // configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = OPA_BITS;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TINT_RED     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TINT_GREEN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TINT_BLUE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OPACITY      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_MATTE = 3'd5;

    typedef logic [NUM_LANES-1:0][CH_BITS-1:0] t_lanes;

    typedef struct packed {
        logic [CH_BITS-1:0] in_red;
        logic [CH_BITS-1:0] in_green;
        logic [CH_BITS-1:0] in_blue;
        logic [CH_BITS-1:0] in_alpha;
        logic [CH_BITS-1:0] matte_value;
    } t_pix_in;

    typedef struct packed {
        logic [CH_BITS-1:0] out_red;
        logic [CH_BITS-1:0] out_green;
        logic [CH_BITS-1:0] out_blue;
        logic [CH_BITS-1:0] out_alpha;
    } t_pix_out;

    typedef struct packed {
        logic [2:0]          blend_mode;
        logic [CH_BITS-1:0]  tint_red;
        logic [CH_BITS-1:0]  tint_green;
        logic [CH_BITS-1:0]  tint_blue;
        logic [OPA_BITS-1:0] opacity;
        logic                invert_matte;
    } t_cfg;

    // front end to mixer
    typedef struct packed {
        logic               valid;
        logic               zero;
        logic [CH_BITS-1:0] alpha;
        logic [CH_BITS-1:0] shadow;
        t_lanes             pix;
        t_lanes             opv;
    } t_fm;

    // mixer to divider
    typedef struct packed {
        logic                              valid;
        logic                              zero;
        logic [CH_BITS-1:0]                alpha;
        logic [NUM_LANES-1:0][NUM_W-1:0]   num;
    } t_md;

endpackage

>>> rtl/core/mtpb_front.sv
// Stages A and B: shadow level and blend op per lane.
module mtpb_front import mtpb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_pix_in i_pix,
    input  t_cfg    i_cfg,
    output t_fm     o_fm
);

    t_lanes in_pix;
    t_lanes tint;

    assign in_pix = {i_pix.in_blue, i_pix.in_green, i_pix.in_red};
    assign tint   = {i_cfg.tint_blue, i_cfg.tint_green, i_cfg.tint_red};

    // ---- stage A ----
    logic                              r_a_valid;
    logic                              r_a_zero;
    logic [CH_BITS-1:0]                r_a_alpha;
    t_lanes                            r_a_pix;
    logic [NUM_LANES-1:0][PROD_W-1:0]  r_a_prod;
    logic [SP_W-1:0]                   r_a_sp;

    logic                              n_a_zero;
    logic [NUM_LANES-1:0][PROD_W-1:0]  n_a_prod;
    logic [SP_W-1:0]                   n_a_sp;
    logic [CH_BITS-1:0]                matte;
    logic [CH_BITS-1:0]                base;
    logic [OPA_BITS-1:0]               opa;

    always_comb begin
        matte    = i_cfg.invert_matte ? (CH_MAX - i_pix.matte_value) : i_pix.matte_value;
        base     = (matte == '0) ? CH_MAX : (CH_MAX - matte);
        opa      = (i_cfg.opacity > OPA_ONE) ? OPA_ONE : i_cfg.opacity;
        n_a_sp   = SP_W'(base) * SP_W'(opa);
        n_a_zero = (i_pix.in_alpha == '0);
        for (int i = 0; i < NUM_LANES; i++) begin
            n_a_prod[i] = PROD_W'(in_pix[i]) * PROD_W'(tint[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_zero  <= n_a_zero;
        r_a_alpha <= i_pix.in_alpha;
        r_a_pix   <= in_pix;
        r_a_prod  <= n_a_prod;
        r_a_sp    <= n_a_sp;
    end

    // ---- stage B ----
    logic               r_b_valid;
    logic               r_b_zero;
    logic [CH_BITS-1:0] r_b_alpha;
    logic [CH_BITS-1:0] r_b_shadow;
    t_lanes             r_b_pix;
    t_lanes             r_b_opv;

    logic [SP_W-1:0]          sp_rnd;
    logic [SP_W-OPA_FRAC-1:0] sh_wide;
    logic [CH_BITS-1:0]       n_b_shadow;
    t_lanes                   n_b_opv;

    always_comb begin
        logic [CH_BITS:0]   sum;
        logic [PROD_W:0]    mdiv;
        logic [CH_BITS-1:0] mres;
        sp_rnd     = r_a_sp + SP_W'(OPA_HALF);
        sh_wide    = sp_rnd[SP_W-1:OPA_FRAC];
        n_b_shadow = (sh_wide > (SP_W-OPA_FRAC)'(CH_MAX)) ? CH_MAX : sh_wide[CH_BITS-1:0];
        for (int i = 0; i < NUM_LANES; i++) begin
            sum  = {1'b0, r_a_pix[i]} + {1'b0, tint[i]};
            // floor(x / MAX) = (x + 1 + (x >> CH_BITS)) >> CH_BITS for x <= MAX*MAX
            mdiv = {1'b0, r_a_prod[i]} + (PROD_W+1)'(1)
                 + (PROD_W+1)'(r_a_prod[i][PROD_W-1:CH_BITS]);
            mres = mdiv[CH_BITS +: CH_BITS];
            unique case (i_cfg.blend_mode)
                MODE_ADD:      n_b_opv[i] = sum[CH_BITS] ? CH_MAX : sum[CH_BITS-1:0];
                MODE_SUB:      n_b_opv[i] = (r_a_pix[i] > tint[i]) ?
                                            (r_a_pix[i] - tint[i]) : '0;
                MODE_MULTIPLY: n_b_opv[i] = mres;
                MODE_LIGHTEN:  n_b_opv[i] = (r_a_pix[i] > tint[i]) ? r_a_pix[i] : tint[i];
                MODE_DARKEN:   n_b_opv[i] = (r_a_pix[i] < tint[i]) ? r_a_pix[i] : tint[i];
                default:       n_b_opv[i] = tint[i];   // over, and unused codes
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_zero   <= r_a_zero;
        r_b_alpha  <= r_a_alpha;
        r_b_shadow <= n_b_shadow;
        r_b_pix    <= r_a_pix;
        r_b_opv    <= n_b_opv;
    end

    assign o_fm = '{valid:  r_b_valid,
                    zero:   r_b_zero,
                    alpha:  r_b_alpha,
                    shadow: r_b_shadow,
                    pix:    r_b_pix,
                    opv:    r_b_opv};

endmodule

>>> rtl/core/mtpb_mix.sv
// Stages C and D: numerator pix*(MAX-sh)*MAX + sh*alpha*op + MAX*MAX/2.
module mtpb_mix import mtpb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_fm  i_fm,
    output t_md  o_md
);

    // ---- stage C ----
    logic                              r_c_valid;
    logic                              r_c_zero;
    logic [CH_BITS-1:0]                r_c_alpha;
    logic [NUM_LANES-1:0][PROD_W-1:0]  r_c_t1;
    logic [PROD_W-1:0]                 r_c_t2;
    t_lanes                            r_c_opv;

    logic [NUM_LANES-1:0][PROD_W-1:0]  n_c_t1;
    logic [PROD_W-1:0]                 n_c_t2;
    logic [CH_BITS-1:0]                keep;

    always_comb begin
        keep   = CH_MAX - i_fm.shadow;
        n_c_t2 = PROD_W'(i_fm.shadow) * PROD_W'(i_fm.alpha);
        for (int i = 0; i < NUM_LANES; i++) begin
            n_c_t1[i] = PROD_W'(i_fm.pix[i]) * PROD_W'(keep);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= i_fm.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_zero  <= i_fm.zero;
        r_c_alpha <= i_fm.alpha;
        r_c_t1    <= n_c_t1;
        r_c_t2    <= n_c_t2;
        r_c_opv   <= i_fm.opv;
    end

    // ---- stage D ----
    logic                             r_d_valid;
    logic                             r_d_zero;
    logic [CH_BITS-1:0]               r_d_alpha;
    logic [NUM_LANES-1:0][NUM_W-1:0]  r_d_num;

    logic [NUM_LANES-1:0][NUM_W-1:0]  n_d_num;

    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            // t1*MAX as shift and subtract
            n_d_num[i] = (NUM_W'(r_c_t1[i]) << CH_BITS) - NUM_W'(r_c_t1[i])
                       + NUM_W'(r_c_t2) * NUM_W'(r_c_opv[i])
                       + NUM_W'(HALF);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_zero  <= r_c_zero;
        r_d_alpha <= r_c_alpha;
        r_d_num   <= n_d_num;
    end

    assign o_md = '{valid: r_d_valid,
                    zero:  r_d_zero,
                    alpha: r_d_alpha,
                    num:   r_d_num};

endmodule

>>> rtl/core/mtpb_div.sv
// Stages E and F: divide by MAX*MAX via reciprocal, correct, clamp.
module mtpb_div import mtpb_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_md      i_md,
    output logic     o_strobe,
    output t_pix_out o_result
);

    // ---- stage E: quotient estimate, low by at most one ----
    logic                             r_e_valid;
    logic                             r_e_zero;
    logic [CH_BITS-1:0]               r_e_alpha;
    logic [NUM_LANES-1:0][NUM_W-1:0]  r_e_num;
    logic [NUM_LANES-1:0][Q_W-1:0]    r_e_q;

    logic [NUM_LANES-1:0][Q_W-1:0]    n_e_q;

    always_comb begin
        logic [2*NUM_W-1:0] prod;
        for (int i = 0; i < NUM_LANES; i++) begin
            prod     = (2*NUM_W)'(i_md.num[i]) * (2*NUM_W)'(RECIP);
            n_e_q[i] = prod[NUM_W +: Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else begin
            r_e_valid <= i_md.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_zero  <= i_md.zero;
        r_e_alpha <= i_md.alpha;
        r_e_num   <= i_md.num;
        r_e_q     <= n_e_q;
    end

    // ---- stage F: remainder fix-up, clamp, transparent force ----
    logic     r_f_valid;
    t_pix_out r_f_res;

    t_lanes   n_f_ch;
    t_pix_out n_f_res;

    always_comb begin
        logic [NUM_W-1:0] rem;
        logic [Q_W-1:0]   q;
        for (int i = 0; i < NUM_LANES; i++) begin
            rem = r_e_num[i] - NUM_W'(r_e_q[i]) * NUM_W'(DEN);
            q   = r_e_q[i] + Q_W'(rem >= NUM_W'(DEN));
            if (r_e_zero) begin
                n_f_ch[i] = '0;
            end else if (q > Q_W'(CH_MAX)) begin
                n_f_ch[i] = CH_MAX;
            end else begin
                n_f_ch[i] = q[CH_BITS-1:0];
            end
        end
        n_f_res = '{out_red:   n_f_ch[0],
                    out_green: n_f_ch[1],
                    out_blue:  n_f_ch[2],
                    out_alpha: r_e_alpha};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else begin
            r_f_valid <= r_e_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f_res <= n_f_res;
    end

    assign o_strobe = r_f_valid;
    assign o_result = r_f_res;

endmodule

>>> rtl/core/matte_tinted_pixel_blend.sv
// Matte tinted pixel blend. Takes one RGBA pixel plus its matte sample per
// clock while busy is low and returns one blended pixel per item, through
// stages A to F, on o_result with o_strobe high for exactly one cycle. The
// path is a fixed six-stage pipeline (shadow and blend op, numerator,
// reciprocal divide by MAX*MAX with a one-step fix-up), so one pixel per
// clock is sustained and results leave in input order. The receiver cannot
// stall: results must be taken the cycle they appear. busy is set in reset,
// cleared when an edge samples i_rst_n high. Configuration registers are
// written through a plain write port (enable, index, data; indexes beyond
// the list are dropped) and must only change while no pixel is in flight,
// since the pipeline reads them live at several stages.
`include "matte_tinted_pixel_blend_macros.svh"

module matte_tinted_pixel_blend import mtpb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // pixel in
    input  logic                  start,
    output logic                  busy,
    input  t_pix_in               i_pix,
    // result out
    output logic                  o_strobe,
    output t_pix_out              o_result,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int PIPE_LAT = 6;    // accept edge to strobe sampled

    // ------------------------------------------------------------------
    // Control: busy only covers reset recovery; the pipe never backs up.
    // ------------------------------------------------------------------
    logic r_busy;
    logic accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy   = r_busy;
    assign accept = start && !r_busy;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BLEND_MODE:   n_cfg.blend_mode   = i_cfg_data[2:0];
                CFG_TINT_RED:     n_cfg.tint_red     = i_cfg_data[CH_BITS-1:0];
                CFG_TINT_GREEN:   n_cfg.tint_green   = i_cfg_data[CH_BITS-1:0];
                CFG_TINT_BLUE:    n_cfg.tint_blue    = i_cfg_data[CH_BITS-1:0];
                CFG_OPACITY:      n_cfg.opacity      = i_cfg_data[OPA_BITS-1:0];
                CFG_INVERT_MATTE: n_cfg.invert_matte = i_cfg_data[0];
                default:          n_cfg = r_cfg;   // unmapped index, dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{blend_mode:   MODE_OVER,
                       tint_red:     CH_MAX,
                       tint_green:   CH_MAX,
                       tint_blue:    CH_MAX,
                       opacity:      OPA_RESET,
                       invert_matte: 1'b0};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // ------------------------------------------------------------------
    // Datapath
    //   A/B: matte -> shadow level (Q16 round), blend op per channel
    //   C/D: pix*(MAX-sh)*MAX + sh*alpha*op + MAX*MAX/2
    //   E/F: quotient by MAX*MAX, clamp, zero-alpha force, result beat
    // ------------------------------------------------------------------
    t_fm fm;
    t_md md;

    mtpb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_pix   (i_pix),
        .i_cfg   (r_cfg),
        .o_fm    (fm)
    );

    mtpb_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fm    (fm),
        .o_md    (md)
    );

    mtpb_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_md     (md),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // every accepted beat comes out as an o_strobe beat
    `MTPB_ASSERT_LAT(a_beat_out, accept, PIPE_LAT, o_strobe)
    // no result beat without an accepted beat behind it
    `MTPB_ASSERT_IMP(a_no_stray, o_strobe, $past(start && !busy && i_rst_n, PIPE_LAT))
    // a transparent pixel leaves as all zero
    `MTPB_ASSERT_IMP(a_clear_px, o_strobe && (o_result.out_alpha == '0), o_result == '0)

endmodule
